FILE: sv/nal_unit_extractor_defines.svh
// assertion macros shared by the nal unit extractor rtl
`ifndef NAL_UNIT_EXTRACTOR_DEFINES_SVH
`define NAL_UNIT_EXTRACTOR_DEFINES_SVH

// condition must never hold outside reset
`define NUE_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define NUE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/nue_pkg.sv
// types, constants and codes for the nal unit extractor
`timescale 1ns / 1ps
package nue_pkg;

  localparam int BUFFER_BYTES = 1048576;
  localparam int CNT_W        = $clog2(BUFFER_BYTES + 1);
  localparam int ADDR_W       = 20;
  localparam int LEN_W        = 21;

  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  // input op codes
  localparam logic [1:0] OP_FIRST = 2'd0;
  localparam logic [1:0] OP_NEXT  = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_PATCH = 2'd1;
  localparam logic [1:0] KIND_DESC  = 2'd2;

  // frame position
  localparam logic [1:0] FP_NONE  = 2'd0;
  localparam logic [1:0] FP_ONE   = 2'd1;
  localparam logic [1:0] FP_CHECK = 2'd2;

  localparam logic [7:0] BYTE_ESC  = 8'h03;
  localparam logic [7:0] BYTE_SC   = 8'h01;
  localparam logic [7:0] BYTE_STOP = 8'h80;

  // everything one input word causes, expanded later by the back end
  typedef struct packed {
    logic              has_write;
    logic [ADDR_W-1:0] w_addr;
    logic [7:0]        w_data;
    logic              w_ovf;
    logic              has_patch;
    logic [ADDR_W-1:0] p_addr;
    logic [7:0]        p_data;
    logic              has_desc;
    logic [ADDR_W-1:0] d_addr;
    logic [LEN_W-1:0]  d_len;
  } nue_task_t;

endpackage

FILE: sv/nue_front.sv
// front end: accepts stream words, tracks unit state, builds result tasks
`timescale 1ns / 1ps
module nue_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  logic [1:0]        op,
  input  logic [7:0]        byte_in,
  input  logic              q_full,
  output logic              push,
  output nue_pkg::nue_task_t task_out
);
  import nue_pkg::*;

  logic [15:0]      byte_window, byte_window_next;
  logic [CNT_W-1:0] write_count, write_count_next;
  logic [CNT_W-1:0] unit_begin, unit_begin_next;
  logic [CNT_W-1:0] last_nonzero_pos, last_nonzero_pos_next;
  logic [7:0]       last_nonzero_value, last_nonzero_value_next;
  logic [1:0]       frame_position, frame_position_next;

  logic             accept;
  logic             zeros, esc, start_code;
  logic             do_store, do_close, upd_nz, store_ok;
  logic [CNT_W-1:0] base, wc_after, unit_end;
  logic [7:0]       patched;
  nue_task_t        tsk;

  assign item_stall = q_full;
  assign accept     = item_valid && !item_stall;
  assign zeros      = (byte_window == 16'h0000);
  assign esc        = zeros && (byte_in == BYTE_ESC);
  assign start_code = zeros && (byte_in == BYTE_SC);
  // lowest set bit cleared
  assign patched    = last_nonzero_value & (last_nonzero_value - 8'd1);

  always_comb begin
    byte_window_next        = byte_window;
    frame_position_next     = frame_position;
    unit_begin_next         = unit_begin;
    last_nonzero_pos_next   = last_nonzero_pos;
    last_nonzero_value_next = last_nonzero_value;
    do_store = 1'b0;
    do_close = 1'b0;
    upd_nz   = 1'b0;
    base     = write_count;
    unique case (op)
      OP_FIRST: begin
        byte_window_next        = {8'h00, byte_in};
        frame_position_next     = FP_ONE;
        unit_begin_next         = '0;
        last_nonzero_pos_next   = '0;
        last_nonzero_value_next = '0;
        base     = '0;
        do_store = 1'b1;
      end
      OP_NEXT: begin
        if (frame_position == FP_ONE) begin
          byte_window_next    = {byte_window[7:0], byte_in};
          frame_position_next = FP_CHECK;
          do_store = 1'b1;
        end else if (frame_position == FP_CHECK) begin
          byte_window_next = {byte_window[7:0], byte_in};
          if (!esc) begin
            do_store = 1'b1;
            do_close = start_code;
            upd_nz   = (byte_in != 8'h00);
          end
        end
      end
      OP_END: begin
        if (frame_position != FP_NONE) begin
          do_close = 1'b1;
          frame_position_next = FP_NONE;
        end
      end
      default: begin
      end
    endcase

    store_ok = (base < CNT_W'(BUFFER_BYTES));
    wc_after = (do_store && store_ok) ? base + CNT_W'(1) : base;
    write_count_next = wc_after;

    tsk = '0;
    if (do_store) begin
      tsk.has_write = 1'b1;
      tsk.w_data    = byte_in;
      tsk.w_ovf     = !store_ok;
      tsk.w_addr    = store_ok ? ADDR_W'(base) : '0;
    end

    unit_end = last_nonzero_pos;
    if (do_close && (last_nonzero_pos != '0)) begin
      if (last_nonzero_value == BYTE_STOP) begin
        unit_end = last_nonzero_pos - CNT_W'(1);
      end else begin
        tsk.has_patch = 1'b1;
        tsk.p_addr    = ADDR_W'(last_nonzero_pos - CNT_W'(1));
        tsk.p_data    = patched;
        last_nonzero_value_next = patched;
      end
      tsk.has_desc = 1'b1;
      tsk.d_addr   = ADDR_W'(unit_begin);
      tsk.d_len    = (unit_end >= unit_begin) ? LEN_W'(unit_end - unit_begin) : '0;
    end
    if (do_close && start_code) begin
      unit_begin_next = wc_after;
    end
    if (upd_nz && store_ok) begin
      last_nonzero_pos_next   = wc_after;
      last_nonzero_value_next = byte_in;
    end
  end

  assign push     = accept && (tsk.has_write || tsk.has_patch || tsk.has_desc);
  assign task_out = tsk;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_window        <= '0;
      write_count        <= '0;
      unit_begin         <= '0;
      last_nonzero_pos   <= '0;
      last_nonzero_value <= '0;
      frame_position     <= FP_NONE;
    end else if (accept) begin
      byte_window        <= byte_window_next;
      write_count        <= write_count_next;
      unit_begin         <= unit_begin_next;
      last_nonzero_pos   <= last_nonzero_pos_next;
      last_nonzero_value <= last_nonzero_value_next;
      frame_position     <= frame_position_next;
    end
  end

endmodule

FILE: sv/nue_queue.sv
// task queue between front end and back end
`timescale 1ns / 1ps
`include "nal_unit_extractor_defines.svh"
module nue_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  nue_pkg::nue_task_t push_task,
  input  logic               pop,
  output logic               full,
  output logic               head_valid,
  output nue_pkg::nue_task_t head_task
);
  import nue_pkg::*;

  nue_task_t         entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr, rptr;
  logic [QCNT_W-1:0] count;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_task  = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_task;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + QPTR_W'(1);
      end
      if (pop) begin
        rptr <= (rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  `NUE_ASSERT_NEVER(a_no_push_full, push && full, "push into full task queue")
  `NUE_ASSERT_NEVER(a_no_pop_empty, pop && !head_valid, "pop from empty task queue")
  `NUE_ASSERT_NEXT(a_count_track, !rst, count == QCNT_W'($past(count) + QCNT_W'($past(push)) - QCNT_W'($past(pop))), "task queue count lost track")

endmodule

FILE: sv/nue_back.sv
// back end: expands each task into result words through an output register
`timescale 1ns / 1ps
module nue_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       head_valid,
  input  nue_pkg::nue_task_t         head_task,
  output logic                       pop,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic [1:0]                 kind,
  output logic [nue_pkg::ADDR_W-1:0] addr,
  output logic [7:0]                 data,
  output logic [nue_pkg::LEN_W-1:0]  unit_length,
  output logic                       overflow,
  output logic                       last
);
  import nue_pkg::*;

  // bit 0 write, bit 1 patch, bit 2 descriptor
  logic [2:0] sent;
  logic [2:0] pending, pick, rest;
  logic       load, is_last;

  assign load    = head_valid && (!result_valid || !result_stall);
  assign pending = {head_task.has_desc, head_task.has_patch, head_task.has_write} & ~sent;
  assign pick    = pending & (~pending + 3'd1);
  assign rest    = pending & ~pick;
  assign is_last = (rest == 3'b000);
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      sent         <= '0;
      result_valid <= 1'b0;
    end else begin
      if (load) begin
        sent <= is_last ? 3'b000 : (sent | pick);
      end
      if (load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      last <= is_last;
      if (pick[0]) begin
        kind        <= KIND_WRITE;
        addr        <= head_task.w_addr;
        data        <= head_task.w_data;
        unit_length <= '0;
        overflow    <= head_task.w_ovf;
      end else if (pick[1]) begin
        kind        <= KIND_PATCH;
        addr        <= head_task.p_addr;
        data        <= head_task.p_data;
        unit_length <= '0;
        overflow    <= 1'b0;
      end else begin
        kind        <= KIND_DESC;
        addr        <= head_task.d_addr;
        data        <= 8'h00;
        unit_length <= head_task.d_len;
        overflow    <= 1'b0;
      end
    end
  end

endmodule

FILE: sv/nal_unit_extractor.sv
// top level of the nal unit extractor
//
//   channel   direction  handshake                    fields
//   item      in         item_valid / item_stall      op, byte_in
//   result    out        result_valid / result_stall  kind, addr, data, unit_length,
//                                                     overflow, last
//
// one input word per cycle while each word causes at most one result and no result_stall
// start codes give up to three results and end of frame up to two, sent by the back end
// one per cycle while result_stall is low; the four-entry task queue absorbs them so the
// front keeps taking words; item_stall rises only when the task queue is full
// result_stall holds the output register; a word goes via the task queue to that register
// synchronous reset clears all control state; the buffer itself lives outside the block
`timescale 1ns / 1ps
module nal_unit_extractor (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  logic [1:0]                 op,
  input  logic [7:0]                 byte_in,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic [1:0]                 kind,
  output logic [nue_pkg::ADDR_W-1:0] addr,
  output logic [7:0]                 data,
  output logic [nue_pkg::LEN_W-1:0]  unit_length,
  output logic                       overflow,
  output logic                       last
);
  import nue_pkg::*;

  logic      push, pop, q_full, head_valid;
  nue_task_t push_task, head_task;

  nue_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .op         (op),
    .byte_in    (byte_in),
    .q_full     (q_full),
    .push       (push),
    .task_out   (push_task)
  );

  nue_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_task  (push_task),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_task  (head_task)
  );

  nue_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_task    (head_task),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .addr         (addr),
    .data         (data),
    .unit_length  (unit_length),
    .overflow     (overflow),
    .last         (last)
  );

endmodule
